// ===== hdl/hbe_pkg.sv =====
`timescale 1ns / 1ps
package hbe_pkg;

   localparam int UNIT_W = 128;

   // Step counts of the shared unit: multiplier bits, dividend bits, root bit pairs.
   localparam logic [6:0] MUL_STEPS  = 7'd34;
   localparam logic [6:0] DIV_STEPS  = 7'd104;
   localparam logic [6:0] SQRT_STEPS = 7'd34;

   localparam logic [55:0] ENERGY_MAX = {1'b0, {55{1'b1}}};
   localparam logic [47:0] GRAD_MAX   = {1'b0, {47{1'b1}}};
   localparam logic [47:0] GRAD_MIN   = {1'b1, {47{1'b0}}};

   typedef logic [UNIT_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
      logic [6:0]  count;
   } unit_req_type;

endpackage

// ===== hdl/harmonic_bond_energy_gradient.sv =====
`timescale 1ns / 1ps
// Harmonic bond stretch term, Q16.16: per beat it takes one bond, forms the
// distance r, adds fc*(r-eq)^2 to a saturating running energy sum (cleared after a
// beat marked last) and, with gradients enabled, returns 2*fc*(r-eq)/r times the
// displacement, saturated to 48 bits (zero for coincident atoms). All multiplies,
// divides and square roots go through one bit-serial unit. Each unit operation is
// a start, its steps and a done pulse: an active term runs three squares, the root,
// two multiplies for the energy and, with gradients, a multiply and a divide per
// component; an inactive term uses no unit operation. One beat is in work at a
// time; the result register lets the next beat be accepted while a result waits.
module harmonic_bond_energy_gradient #(
   parameter int ATOM_INDEX_BITS = 16,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_atom_i,
   input  logic [15:0]        req_atom_j,
   input  logic signed [31:0] req_xi,
   input  logic signed [31:0] req_yi,
   input  logic signed [31:0] req_zi,
   input  logic signed [31:0] req_xj,
   input  logic signed [31:0] req_yj,
   input  logic signed [31:0] req_zj,
   input  logic [31:0]        req_eq_length,
   input  logic [31:0]        req_force_constant,
   input  logic               req_active,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_out_atom_i,
   output logic [15:0]        rsp_out_atom_j,
   output logic signed [47:0] rsp_grad_x,
   output logic signed [47:0] rsp_grad_y,
   output logic signed [47:0] rsp_grad_z,
   output logic signed [55:0] rsp_energy_sum,
   output logic               rsp_zero_distance,
   output logic               rsp_out_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import hbe_pkg::*;

   localparam logic [15:0] ATOM_MASK = (ATOM_INDEX_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << ATOM_INDEX_BITS) - 32'd1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_ROOT, ST_PROD, ST_ENERGY,
      ST_NUM, ST_QUOT, ST_DONE
   } state_type;

   state_type    state_ff;
   logic         go_ff;
   logic         grad_en_ff;
   logic [15:0]  atom_i_ff, atom_j_ff;
   logic         last_ff;
   logic [32:0]  mag_ff [3];
   logic [2:0]   dsign_ff;
   logic [31:0]  eq_ff, fc_ff;
   logic [66:0]  s_ff;
   logic [33:0]  r_ff;
   logic [33:0]  ad_ff;
   logic         dneg_ff;
   logic         zero_ff;
   logic [65:0]  p_ff;
   logic [100:0] num_ff;
   logic [55:0]  et_ff;
   logic [55:0]  acc_ff;
   logic [47:0]  grad_ff [3];
   logic [1:0]   axis_ff;

   unit_req_type ureq;
   word_type     opa, opb, ures;
   logic         udone;

   logic signed [32:0] dx, dy, dz;
   logic [32:0]  mx, my, mz;
   word_type     e_sh;
   logic [55:0]  e_term;
   logic [47:0]  g_val;
   logic         g_neg;
   logic [56:0]  acc_sum;
   logic [55:0]  acc_in;
   logic [33:0]  r_in;
   logic         go_in;

   hbe_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .req    (ureq),
      .opa    (opa),
      .opb    (opb),
      .done   (udone),
      .result (ures)
   );

   always_comb begin
      dx = {req_xi[31], req_xi} - {req_xj[31], req_xj};
      dy = {req_yi[31], req_yi} - {req_yj[31], req_yj};
      dz = {req_zi[31], req_zi} - {req_zj[31], req_zj};
      mx = dx[32] ? 33'(-dx) : 33'(dx);
      my = dy[32] ? 33'(-dy) : 33'(dy);
      mz = dz[32] ? 33'(-dz) : 33'(dz);

      ureq.start = go_ff;
      ureq.op    = OP_MUL;
      ureq.count = MUL_STEPS;
      opa = '0;
      opb = '0;
      case (state_ff)
         ST_SQX: begin
            opa = UNIT_W'(mag_ff[0]);
            opb = {1'b0, mag_ff[0], 94'b0};
         end
         ST_SQY: begin
            opa = UNIT_W'(mag_ff[1]);
            opb = {1'b0, mag_ff[1], 94'b0};
         end
         ST_SQZ: begin
            opa = UNIT_W'(mag_ff[2]);
            opb = {1'b0, mag_ff[2], 94'b0};
         end
         ST_ROOT: begin
            ureq.op    = OP_SQRT;
            ureq.count = SQRT_STEPS;
            opb = {1'b0, s_ff, 60'b0};
         end
         ST_PROD: begin
            opa = UNIT_W'(fc_ff);
            opb = {ad_ff, 94'b0};
         end
         ST_ENERGY: begin
            opa = UNIT_W'(p_ff);
            opb = {ad_ff, 94'b0};
         end
         ST_NUM: begin
            opa = UNIT_W'({p_ff, 1'b0});
            opb = {1'b0, mag_ff[axis_ff], 94'b0};
         end
         ST_QUOT: begin
            ureq.op    = OP_DIV;
            ureq.count = DIV_STEPS;
            opa = UNIT_W'(r_ff) << COORD_FRAC_BITS;
            opb = {3'b0, num_ff, 24'b0};
         end
         default: begin
         end
      endcase

      // Each step that needs the unit starts it in the cycle after the previous step ends.
      case (state_ff)
         ST_IDLE:   go_in = req_valid && req_active;
         ST_SQX, ST_SQY, ST_SQZ, ST_ROOT, ST_PROD, ST_NUM: go_in = udone;
         ST_ENERGY: go_in = udone && !zero_ff && grad_en_ff;
         ST_QUOT:   go_in = udone && (axis_ff != 2'd2);
         default:   go_in = 1'b0;
      endcase

      e_sh   = ures >> (2 * COORD_FRAC_BITS);
      e_term = (e_sh[UNIT_W-1:55] != '0) ? ENERGY_MAX : e_sh[55:0];
      r_in   = ures[33:0];

      // Gradient sign follows sign(r-eq) times the sign of the component.
      g_neg = dneg_ff ^ dsign_ff[axis_ff];
      if (ures == '0)
         g_val = '0;
      else if (ures[UNIT_W-1:47] != '0)
         g_val = g_neg ? GRAD_MIN : GRAD_MAX;
      else
         g_val = g_neg ? 48'(-ures[47:0]) : ures[47:0];

      acc_sum = {1'b0, acc_ff} + {1'b0, et_ff};
      acc_in  = (acc_sum > {1'b0, ENERGY_MAX}) ? ENERGY_MAX : acc_sum[55:0];
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'b0, grad_en_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         go_ff      <= 1'b0;
         grad_en_ff <= 1'b1;
         acc_ff     <= '0;
         rsp_valid  <= 1'b0;
         axis_ff    <= '0;
      end else begin
         go_ff <= go_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2])
            grad_en_ff <= csr_pwdata[0];
         if (rsp_valid && rsp_ready && state_ff != ST_DONE)
            rsp_valid <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  atom_i_ff  <= req_atom_i & ATOM_MASK;
                  atom_j_ff  <= req_atom_j & ATOM_MASK;
                  last_ff    <= req_last;
                  mag_ff[0]  <= mx;
                  mag_ff[1]  <= my;
                  mag_ff[2]  <= mz;
                  dsign_ff   <= {dz[32], dy[32], dx[32]};
                  eq_ff      <= req_eq_length;
                  fc_ff      <= req_force_constant;
                  et_ff      <= '0;
                  zero_ff    <= 1'b0;
                  grad_ff[0] <= '0;
                  grad_ff[1] <= '0;
                  grad_ff[2] <= '0;
                  axis_ff    <= '0;
                  if (req_active) begin
                     state_ff <= ST_SQX;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SQX: if (udone) begin
               s_ff     <= ures[66:0];
               state_ff <= ST_SQY;
            end
            ST_SQY: if (udone) begin
               s_ff     <= s_ff + ures[66:0];
               state_ff <= ST_SQZ;
            end
            ST_SQZ: if (udone) begin
               s_ff     <= s_ff + ures[66:0];
               state_ff <= ST_ROOT;
            end
            ST_ROOT: if (udone) begin
               r_ff    <= r_in;
               zero_ff <= (r_in == '0);
               dneg_ff <= (r_in < {2'b0, eq_ff});
               ad_ff   <= (r_in < {2'b0, eq_ff}) ? ({2'b0, eq_ff} - r_in)
                                                 : (r_in - {2'b0, eq_ff});
               state_ff <= ST_PROD;
            end
            ST_PROD: if (udone) begin
               p_ff     <= ures[65:0];
               state_ff <= ST_ENERGY;
            end
            ST_ENERGY: if (udone) begin
               et_ff <= e_term;
               if (zero_ff || !grad_en_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_NUM;
               end
            end
            ST_NUM: if (udone) begin
               num_ff   <= ures[100:0];
               state_ff <= ST_QUOT;
            end
            ST_QUOT: if (udone) begin
               grad_ff[axis_ff] <= g_val;
               if (axis_ff == 2'd2) begin
                  state_ff <= ST_DONE;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= ST_NUM;
               end
            end
            ST_DONE: begin
               // The result register takes the beat once it is empty or being drained.
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid         <= 1'b1;
                  rsp_out_atom_i    <= atom_i_ff;
                  rsp_out_atom_j    <= atom_j_ff;
                  rsp_grad_x        <= grad_ff[0];
                  rsp_grad_y        <= grad_ff[1];
                  rsp_grad_z        <= grad_ff[2];
                  rsp_energy_sum    <= acc_in;
                  rsp_zero_distance <= zero_ff;
                  rsp_out_last      <= last_ff;
                  acc_ff            <= last_ff ? '0 : acc_in;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_zero_no_grad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_distance) |->
         (rsp_grad_x == '0 && rsp_grad_y == '0 && rsp_grad_z == '0))
      else $error("gradient on coincident atoms");
   a_energy_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_energy_sum[55]) else $error("negative energy sum");
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second beat taken");
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      !acc_ff[55]) else $error("energy accumulator out of range");
`endif

endmodule

// ===== hdl/hbe_unit.sv =====
`timescale 1ns / 1ps
module hbe_unit (
   input  logic               clock,
   input  logic               reset,
   input  hbe_pkg::unit_req_type req,
   input  hbe_pkg::word_type  opa,
   input  hbe_pkg::word_type  opb,
   output logic               done,
   output hbe_pkg::word_type  result
);
   import hbe_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   unit_op_type op_ff;
   logic [6:0]  cnt_ff;
   word_type    a_ff;
   word_type    sh_ff;
   word_type    acc_ff;
   word_type    res_ff;

   word_type     rem_sh;
   word_type     addend;
   logic [UNIT_W:0] sum;
   logic         fits;

   // One adder serves all three operations: shift-add for the multiply,
   // trial subtract for the divide and the root.
   always_comb begin
      case (op_ff)
         OP_DIV: begin
            rem_sh = {acc_ff[UNIT_W-2:0], sh_ff[UNIT_W-1]};
            addend = ~a_ff;
         end
         OP_SQRT: begin
            rem_sh = {acc_ff[UNIT_W-3:0], sh_ff[UNIT_W-1:UNIT_W-2]};
            addend = ~{res_ff[UNIT_W-3:0], 2'b01};
         end
         default: begin
            rem_sh = {acc_ff[UNIT_W-2:0], 1'b0};
            addend = sh_ff[UNIT_W-1] ? a_ff : '0;
         end
      endcase
      sum  = {1'b0, rem_sh} + {1'b0, addend} + {{UNIT_W{1'b0}}, (op_ff != OP_MUL)};
      fits = sum[UNIT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !req.start && busy_ff && (cnt_ff == 7'd1);
         if (req.start) begin
            busy_ff <= 1'b1;
            op_ff   <= req.op;
            cnt_ff  <= req.count;
            a_ff    <= opa;
            sh_ff   <= opb;
            acc_ff  <= '0;
            res_ff  <= '0;
         end else if (busy_ff) begin
            case (op_ff)
               OP_MUL: begin
                  acc_ff <= sum[UNIT_W-1:0];
                  sh_ff  <= {sh_ff[UNIT_W-2:0], 1'b0};
               end
               OP_DIV: begin
                  acc_ff <= fits ? sum[UNIT_W-1:0] : rem_sh;
                  res_ff <= {res_ff[UNIT_W-2:0], fits};
                  sh_ff  <= {sh_ff[UNIT_W-2:0], 1'b0};
               end
               default: begin
                  acc_ff <= fits ? sum[UNIT_W-1:0] : rem_sh;
                  res_ff <= {res_ff[UNIT_W-2:0], fits};
                  sh_ff  <= {sh_ff[UNIT_W-3:0], 2'b00};
               end
            endcase
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = (op_ff == OP_MUL) ? acc_ff : res_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("unit started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("unit done without work");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("unit still busy at done");
`endif

endmodule

// ===== tb/sv/hbe_checker.sv =====
`timescale 1ns / 1ps
module hbe_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [15:0]        req_atom_i,
   input  logic [15:0]        req_atom_j,
   input  logic signed [31:0] req_xi,
   input  logic signed [31:0] req_yi,
   input  logic signed [31:0] req_zi,
   input  logic signed [31:0] req_xj,
   input  logic signed [31:0] req_yj,
   input  logic signed [31:0] req_zj,
   input  logic [31:0]        req_eq_length,
   input  logic [31:0]        req_force_constant,
   input  logic               req_active,
   input  logic               req_last,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [15:0]        rsp_out_atom_i,
   input  logic [15:0]        rsp_out_atom_j,
   input  logic signed [47:0] rsp_grad_x,
   input  logic signed [47:0] rsp_grad_y,
   input  logic signed [47:0] rsp_grad_z,
   input  logic signed [55:0] rsp_energy_sum,
   input  logic               rsp_zero_distance,
   input  logic               rsp_out_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending_beats
);
   import hbe_pkg::*;

   localparam int FRAC = 16;
   localparam logic [2:0] ADDR_GRADIENTS_ENABLED = 3'd0;

   typedef struct {
      logic [15:0] atom_i;
      logic [15:0] atom_j;
      logic [47:0] gx;
      logic [47:0] gy;
      logic [47:0] gz;
      logic [55:0] energy;
      logic        zero_dist;
      logic        last;
   } bond_result_type;

   bond_result_type expected_q[$];
   logic [55:0]  energy_acc;
   logic         grads_on;

   function automatic logic [127:0] mag(input longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic logic [47:0] grad_part(input logic [127:0] twice_p, input longint dc,
                                             input logic stretch_neg,
                                             input logic [127:0] divisor);
      logic [127:0] q;
      logic         neg;
      q   = (twice_p * mag(dc)) / divisor;
      neg = stretch_neg != (dc < 0);
      if (q == 0) return '0;
      if (q > 128'(GRAD_MAX)) return neg ? GRAD_MIN : GRAD_MAX;
      return neg ? 48'(-q) : q[47:0];
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   // Works out the result of one accepted bond beat and advances the energy sum.
   task automatic predict_bond(output bond_result_type res);
      longint       dx, dy, dz, disp;
      logic [127:0] sq, cand, root, ad, p, e, et;
      logic [56:0]  total;
      dx = longint'(req_xi) - longint'(req_xj);
      dy = longint'(req_yi) - longint'(req_yj);
      dz = longint'(req_zi) - longint'(req_zj);
      res = '{req_atom_i, req_atom_j, '0, '0, '0, '0, 1'b0, req_last};
      if (req_active) begin
         sq = mag(dx) * mag(dx) + mag(dy) * mag(dy) + mag(dz) * mag(dz);
         root = 0;
         for (int b = 33; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq) root = cand;
         end
         disp = longint'(root) - longint'(req_eq_length);
         ad = mag(disp);
         p = 128'(req_force_constant) * ad;
         e = (p * ad) >> (2 * FRAC);
         et = (e > 128'(ENERGY_MAX)) ? 128'(ENERGY_MAX) : e;
         total = 57'(energy_acc) + 57'(et);
         energy_acc = (total > 57'(ENERGY_MAX)) ? ENERGY_MAX : total[55:0];
         if (root == 0) begin
            res.zero_dist = 1'b1;
         end else if (grads_on) begin
            res.gx = grad_part(p + p, dx, disp < 0, root << FRAC);
            res.gy = grad_part(p + p, dy, disp < 0, root << FRAC);
            res.gz = grad_part(p + p, dz, disp < 0, root << FRAC);
         end
      end
      res.energy = energy_acc;
      if (req_last) energy_acc = '0;
   endtask

   initial begin
      fail_count    = 0;
      pending_beats = 0;
      energy_acc    = '0;
      grads_on      = 1'b1;
   end

   always @(posedge clock) begin
      bond_result_type want, fresh;
      if (reset) begin
         energy_acc = '0;
         grads_on   = 1'b1;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_GRADIENTS_ENABLED)
            grads_on = csr_pwdata[0];
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("result beat with nothing expected at %0t", $realtime);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_out_atom_i !== want.atom_i)
                  report_mismatch("out_atom_i", 64'(rsp_out_atom_i), 64'(want.atom_i));
               if (rsp_out_atom_j !== want.atom_j)
                  report_mismatch("out_atom_j", 64'(rsp_out_atom_j), 64'(want.atom_j));
               if (rsp_grad_x !== want.gx)
                  report_mismatch("grad_x", 64'(rsp_grad_x), 64'(want.gx));
               if (rsp_grad_y !== want.gy)
                  report_mismatch("grad_y", 64'(rsp_grad_y), 64'(want.gy));
               if (rsp_grad_z !== want.gz)
                  report_mismatch("grad_z", 64'(rsp_grad_z), 64'(want.gz));
               if (rsp_energy_sum !== want.energy)
                  report_mismatch("energy_sum", 64'(rsp_energy_sum), 64'(want.energy));
               if (rsp_zero_distance !== want.zero_dist)
                  report_mismatch("zero_distance", 64'(rsp_zero_distance),
                                  64'(want.zero_dist));
               if (rsp_out_last !== want.last)
                  report_mismatch("out_last", 64'(rsp_out_last), 64'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            predict_bond(fresh);
            expected_q.push_back(fresh);
         end
      end
      pending_beats = expected_q.size();
   end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   localparam logic [2:0] ADDR_GRADIENTS_ENABLED = 3'd0;
   localparam int CYCLE_LIMIT = 6000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_atom_i = '0;
   logic [15:0]        req_atom_j = '0;
   logic signed [31:0] req_xi = '0;
   logic signed [31:0] req_yi = '0;
   logic signed [31:0] req_zi = '0;
   logic signed [31:0] req_xj = '0;
   logic signed [31:0] req_yj = '0;
   logic signed [31:0] req_zj = '0;
   logic [31:0]        req_eq_length = '0;
   logic [31:0]        req_force_constant = '0;
   logic               req_active = 1'b0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_out_atom_i;
   logic [15:0]        rsp_out_atom_j;
   logic signed [47:0] rsp_grad_x;
   logic signed [47:0] rsp_grad_y;
   logic signed [47:0] rsp_grad_z;
   logic signed [55:0] rsp_energy_sum;
   logic               rsp_zero_distance;
   logic               rsp_out_last;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 fail_count;
   int                 pending_beats;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   harmonic_bond_energy_gradient DUT (.*);
   hbe_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: switches now and then among always ready, random and long stalls.
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 19) == 0);
      endcase
   end

   // The last beat sent is already taken, so valid drops before waiting.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_beats != 0);
      @(posedge clock);
   endtask

   task automatic write_grads(input logic value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_GRADIENTS_ENABLED;
      csr_pwdata  <= {$urandom} & ~32'd1 | 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_bond(input logic [31:0] xi, yi, zi, xj, yj, zj, eq, fc,
                            input logic active, last);
      logic took;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_atom_i         <= 16'($urandom);
      req_atom_j         <= 16'($urandom);
      req_xi             <= xi;
      req_yi             <= yi;
      req_zi             <= zi;
      req_xj             <= xj;
      req_yj             <= yj;
      req_zj             <= zj;
      req_eq_length      <= eq;
      req_force_constant <= fc;
      req_active         <= active;
      req_last           <= last;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
   endtask

   // Mostly near bonds with an eq close to the distance, some wide spans and some
   // coincident atoms.
   task automatic send_random_bond();
      logic [31:0] xi, yi, zi, xj, yj, zj, eq, fc;
      int          span, shape;
      xi = $urandom; yi = $urandom; zi = $urandom;
      shape = $urandom_range(0, 99);
      span = $urandom_range(4, 24);
      if (shape < 4) begin
         xj = xi; yj = yi; zj = zi;
      end else if (shape < 20) begin
         xj = $urandom; yj = $urandom; zj = $urandom;
      end else begin
         xj = xi + ($urandom >> (32 - span)) - (32'd1 << (span - 1));
         yj = yi + ($urandom >> (32 - span)) - (32'd1 << (span - 1));
         zj = zi + ($urandom >> (32 - span)) - (32'd1 << (span - 1));
      end
      eq = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> (32 - span));
      fc = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> $urandom_range(8, 30));
      send_bond(xi, yi, zi, xj, yj, zj, eq, fc, $urandom_range(0, 9) != 0,
                $urandom_range(0, 9) == 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, coincidence, inactive terms, saturation, both settings.
      send_bond(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'd0, 32'hffffffff, 1'b1, 1'b0);
      send_bond(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                32'h80000000, 32'hffffffff, 32'hffffffff, 1'b1, 1'b0);
      send_bond('0, '0, '0, '0, '0, '0, 32'hffffffff, 32'hffffffff, 1'b1, 1'b0);
      send_bond(32'h00010000, '0, '0, '0, '0, '0, 32'h00010000, 32'h00010000, 1'b1, 1'b1);
      send_bond(32'h1234, 32'h5678, 32'h9abc, '0, '0, '0, '0, 32'h00010000, 1'b1, 1'b0);
      send_bond(32'h00010000, '0, '0, '0, '0, '0, 32'hffffffff, 32'hffffffff, 1'b0, 1'b1);
      send_bond('0, 32'h00000001, '0, '0, '0, '0, '0, 32'hffffffff, 1'b1, 1'b0);
      send_bond('0, '0, 32'h80000000, '0, '0, 32'h7fffffff, 32'h00020000, 32'd1,
                1'b1, 1'b0);
      send_bond(32'h55555555, 32'haaaaaaaa, '0, 32'haaaaaaaa, 32'h55555555, '0,
                32'h00008000, '0, 1'b1, 1'b0);
      send_bond(32'h00030000, 32'h00040000, '0, '0, '0, '0, 32'h00050000,
                32'h00010000, 1'b1, 1'b1);
      send_bond(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h00010000, 32'h00010000, 1'b1, 1'b1);
      wait_drained();
      write_grads(1'b0);
      send_bond(32'h7fffffff, '0, '0, 32'h80000000, '0, '0, 32'd5, 32'hffffffff,
                1'b1, 1'b0);
      send_bond('0, '0, '0, '0, '0, '0, 32'h00010000, 32'h00010000, 1'b1, 1'b0);
      send_bond(32'h00030000, 32'h00040000, '0, '0, '0, '0, '0, 32'h00010000,
                1'b0, 1'b1);
      wait_drained();
      write_grads(1'b1);

      repeat (500) send_random_bond();
      wait_drained();
      write_grads(1'b0);
      repeat (250) send_random_bond();
      wait_drained();
      write_grads(1'b1);
      for (int n = 0; n < 400; n++) begin
         if (n == 200) begin
            burst_left = 0;
            wait_drained();
         end
         send_random_bond();
      end
      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
